// File: rtl/quoted_printable_decoder_top_macros.svh
`ifndef QUOTED_PRINTABLE_DECODER_TOP_MACROS_SVH
`define QUOTED_PRINTABLE_DECODER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define QPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/qpd_pkg.sv
package qpd_pkg;

  localparam int QDEPTH = 2;
  localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] PRINT_LO  = 8'd33;
  localparam logic [7:0] PRINT_HI  = 8'd126;
  localparam logic [7:0] DIGIT_LO  = 8'h30;
  localparam logic [7:0] DIGIT_HI  = 8'h39;
  localparam logic [7:0] UHEX_LO   = 8'h41;
  localparam logic [7:0] UHEX_HI   = 8'h46;
  localparam logic [3:0] UHEX_OFS  = 4'd9;

  typedef struct packed {
    logic [7:0] data;
    logic       pass;
    logic       eq;
    logic       brk;
    logic       hex;
    logic [3:0] nib;
  } qpd_cls_t;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
  } qpd_res_t;

endpackage

// File: rtl/qpd_front.sv
module qpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [7:0]        data_byte_i,
  output logic              mid_valid_o,
  output qpd_pkg::qpd_cls_t mid_o,
  input  logic              mid_pop_i
);

  qpd_pkg::qpd_cls_t               cls;
  qpd_pkg::qpd_cls_t               mem_q [qpd_pkg::QDEPTH];
  logic [qpd_pkg::QIDX_W-1:0]      wptr_q, wptr_d, rptr_q, rptr_d;
  logic [qpd_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                            push_ok, pop_ok;

  always_comb begin
    cls      = '0;
    cls.data = data_byte_i;
    cls.eq   = (data_byte_i == qpd_pkg::CH_EQUALS);
    cls.brk  = (data_byte_i == qpd_pkg::CH_CR) || (data_byte_i == qpd_pkg::CH_LF);
    cls.pass = !cls.eq && (data_byte_i inside {[qpd_pkg::CH_TAB:qpd_pkg::CH_CR],
                                               qpd_pkg::CH_SPACE,
                                               [qpd_pkg::PRINT_LO:qpd_pkg::PRINT_HI]});
    if (data_byte_i inside {[qpd_pkg::DIGIT_LO:qpd_pkg::DIGIT_HI]}) begin
      cls.hex = 1'b1;
      cls.nib = data_byte_i[3:0];
    end else if (data_byte_i inside {[qpd_pkg::UHEX_LO:qpd_pkg::UHEX_HI]}) begin
      cls.hex = 1'b1;
      cls.nib = data_byte_i[3:0] + qpd_pkg::UHEX_OFS;
    end
  end

  assign full_o      = (cnt_q == qpd_pkg::QCNT_W'(qpd_pkg::QDEPTH));
  assign mid_valid_o = (cnt_q != '0);
  assign mid_o       = mem_q[rptr_q];
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = mid_pop_i && mid_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_ok) begin
      wptr_d = (wptr_q == qpd_pkg::QIDX_W'(qpd_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_ok) begin
      rptr_d = (rptr_q == qpd_pkg::QIDX_W'(qpd_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wptr_q] <= cls;
    end
  end

endmodule

// File: rtl/qpd_back.sv
module qpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mid_valid_i,
  input  qpd_pkg::qpd_cls_t mid_i,
  output logic              mid_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        out_byte_o,
  output logic              is_error_o
);

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_HEX2   = 2'd2;
  localparam logic [1:0] MODE_CONT   = 2'd3;

  logic [1:0]                  mode_q, mode_d;
  logic [3:0]                  nib_q, nib_d;
  logic                        emit;
  qpd_pkg::qpd_res_t           res;
  qpd_pkg::qpd_res_t           mem_q [qpd_pkg::QDEPTH];
  logic [qpd_pkg::QIDX_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [qpd_pkg::QCNT_W-1:0]  cnt_q, cnt_d;
  logic                        full, take, push_ok, pop_ok;

  assign full      = (cnt_q == qpd_pkg::QCNT_W'(qpd_pkg::QDEPTH));
  assign take      = mid_valid_i && !full;
  assign mid_pop_o = take;

  always_comb begin
    mode_d   = mode_q;
    nib_d    = nib_q;
    emit     = 1'b0;
    res.data = mid_i.data;
    res.err  = 1'b0;
    case (mode_q)
      MODE_NORMAL: begin
        if (mid_i.pass) begin
          emit = 1'b1;
        end else if (mid_i.eq) begin
          mode_d = MODE_ESCAPE;
        end else begin
          emit = 1'b1;
          res.err = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        if (mid_i.brk) begin
          mode_d = MODE_CONT;
        end else if (mid_i.hex) begin
          nib_d  = mid_i.nib;
          mode_d = MODE_HEX2;
        end else begin
          emit    = 1'b1;
          res.err = 1'b1;
          mode_d  = MODE_NORMAL;
        end
      end
      MODE_HEX2: begin
        emit   = 1'b1;
        mode_d = MODE_NORMAL;
        if (mid_i.hex) begin
          res.data = {nib_q, mid_i.nib};
        end else begin
          res.err = 1'b1;
        end
      end
      MODE_CONT: begin
        if (mid_i.brk) begin
          mode_d = MODE_CONT;
        end else if (mid_i.eq) begin
          mode_d = MODE_ESCAPE;
        end else begin
          emit    = 1'b1;
          res.err = !mid_i.pass;
          mode_d  = MODE_NORMAL;
        end
      end
      default: begin
        mode_d = MODE_NORMAL;
      end
    endcase
    if (res.err) begin
      res.data = '0;
    end
  end

  assign push_ok    = take && emit;
  assign empty_o    = (cnt_q == '0);
  assign pop_ok     = pop_i && !empty_o;
  assign out_byte_o = mem_q[rptr_q].data;
  assign is_error_o = mem_q[rptr_q].err;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_ok) begin
      wptr_d = (wptr_q == qpd_pkg::QIDX_W'(qpd_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_ok) begin
      rptr_d = (rptr_q == qpd_pkg::QIDX_W'(qpd_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      nib_q  <= '0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (take) begin
        mode_q <= mode_d;
        nib_q  <= nib_d;
      end
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wptr_q] <= res;
    end
  end

endmodule

// File: rtl/quoted_printable_decoder_top.sv
// Accepted bytes are queued in the front end; decoded results are registered in the back queue.
// Throughput: one byte per cycle while full is low; the back end updates its mode for each byte it takes.
// Front and back each hold a 2-word queue, so either side may stall without losing a byte.
// Reset (rst_ni low, asynchronous): mode returns to normal, nibble clears, queues empty.
module quoted_printable_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       is_error_o
);

  qpd_pkg::qpd_cls_t mid;
  logic              mid_valid, mid_pop;

  qpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .data_byte_i (data_byte_i),
    .mid_valid_o (mid_valid),
    .mid_o       (mid),
    .mid_pop_i   (mid_pop)
  );

  qpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_i       (mid),
    .mid_pop_o   (mid_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_byte_o  (out_byte_o),
    .is_error_o  (is_error_o)
  );

endmodule

// File: rtl/qpd_checker.sv
`include "quoted_printable_decoder_top_macros.svh"

module qpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic [7:0] data_byte_i,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       is_error_o
);

  `QPD_ASSERT_NOW(a_err_zero, !empty && is_error_o, out_byte_o == 8'd0, "error word with data")
  `QPD_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(out_byte_o) && $stable(is_error_o), "waiting word changed")
  `QPD_ASSERT_NOW(a_no_loss, $rose(empty), $past(pop), "word vanished without pop")

endmodule

bind quoted_printable_decoder_top qpd_checker u_qpd_checker (.*);

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qpd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int WORD_COUNT  = 750;
  localparam int FILL_AT     = 300;
  localparam int FILL_HOLD   = 200;

  typedef enum logic [1:0] {
    QP_NORMAL,
    QP_ESCAPE,
    QP_HEX2,
    QP_CONT
  } qp_mode_e;

  class qp_scoreboard;
    qpd_res_t pending[$];
    qp_mode_e mode;
    logic [3:0] nibble;
    int mismatches;

    function new();
      mode = QP_NORMAL;
      nibble = '0;
      mismatches = 0;
    endfunction

    function bit is_plain(logic [7:0] c);
      if (c >= PRINT_LO && c <= PRINT_HI && c != CH_EQUALS) return 1'b1;
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // bit 4 set: not an uppercase hex digit
    function logic [4:0] hex_of(logic [7:0] c);
      if (c >= DIGIT_LO && c <= DIGIT_HI) return {1'b0, 4'(c - DIGIT_LO)};
      if (c >= UHEX_LO && c <= UHEX_HI) return {1'b0, 4'(c - UHEX_LO + 8'd10)};
      return 5'h10;
    endfunction

    function void note_byte(logic [7:0] c);
      logic [4:0] hv;
      bit brk;
      bit bad;
      bit emit;
      qpd_res_t r;
      hv = hex_of(c);
      brk = (c == CH_CR || c == CH_LF);
      bad = 1'b0;
      emit = 1'b0;
      r = '0;
      case (mode)
        QP_NORMAL: begin
          if (is_plain(c)) begin
            r.data = c;
            emit = 1'b1;
          end else if (c == CH_EQUALS) begin
            mode = QP_ESCAPE;
          end else begin
            bad = 1'b1;
          end
        end
        QP_ESCAPE: begin
          if (brk) begin
            mode = QP_CONT;
          end else if (!hv[4]) begin
            nibble = hv[3:0];
            mode = QP_HEX2;
          end else begin
            bad = 1'b1;
          end
        end
        QP_HEX2: begin
          if (!hv[4]) begin
            r.data = {nibble, hv[3:0]};
            emit = 1'b1;
            mode = QP_NORMAL;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          if (brk) begin
          end else if (c == CH_EQUALS) begin
            mode = QP_ESCAPE;
          end else if (is_plain(c)) begin
            r.data = c;
            emit = 1'b1;
            mode = QP_NORMAL;
          end else begin
            bad = 1'b1;
          end
        end
      endcase
      if (bad) begin
        r.data = '0;
        r.err = 1'b1;
        emit = 1'b1;
        mode = QP_NORMAL;
      end
      if (emit) pending.push_back(r);
    endfunction

    function void check_result(logic [7:0] data, logic err);
      qpd_res_t exp_res;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: out_byte %h is_error %b", data, err);
        return;
      end
      exp_res = pending.pop_front();
      if (data !== exp_res.data || err !== exp_res.err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: out_byte exp %h got %h, is_error exp %b got %b",
                   exp_res.data, data, exp_res.err, err);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] data_byte_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte_o;
  logic       is_error_o;

  qp_scoreboard sb = new();
  int bytes_sent = 0;
  int cycles = 0;
  bit bursts_on = 1'b1;

  quoted_printable_decoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .data_byte_i(data_byte_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .is_error_o (is_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(out_byte_o, is_error_o);
  end

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 8) begin
      do c = 8'($urandom_range(33, 126)); while (c == CH_EQUALS);
    end else begin
      case ($urandom_range(0, 5))
        0: c = CH_SPACE;
        1: c = CH_TAB;
        2: c = CH_LF;
        3: c = 8'h0B;
        4: c = 8'h0C;
        default: c = CH_CR;
      endcase
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    return (v < 10) ? 8'(DIGIT_LO + v) : 8'(UHEX_LO + v - 10);
  endfunction

  task automatic push_byte(logic [7:0] b);
    int gap;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // receiver: random stalls, plus one long hold so the block backs up
  initial begin
    int hold;
    bit filled;
    hold = 0;
    filled = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!filled && bytes_sent >= FILL_AT) begin
        filled = 1'b1;
        hold = FILL_HOLD;
      end else if (hold == 0 && bursts_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 9);
      end
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int kind;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    data_byte_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_text("A!~ \t\n\v\f\r");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("=0F=9A=\r\nx==");
    push_text("=a=4==\n");
    push_byte(8'h80);

    while (bytes_sent < WORD_COUNT) begin
      if (bytes_sent > WORD_COUNT - 100) bursts_on = 1'b0;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        push_byte(plain_char());
      end else if (kind < 70) begin
        push_byte(CH_EQUALS);
        push_byte(hex_char());
        push_byte(hex_char());
      end else if (kind < 80) begin
        push_byte(CH_EQUALS);
        repeat ($urandom_range(1, 3)) push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
        if ($urandom_range(0, 1)) begin
          push_byte(plain_char());
        end else begin
          push_byte(CH_EQUALS);
          push_byte(hex_char());
          push_byte(hex_char());
        end
      end else if (kind < 90) begin
        push_byte(CH_EQUALS);
        if ($urandom_range(0, 1)) push_byte(hex_char());
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
